>>> src/l3sf_pkg.sv
// Shared constants and types of the 3x3 Laplacian stencil filter.
package l3sf_pkg;

  localparam int DEF_MAX_ROWS    = 1024;
  localparam int DEF_MAX_COLS    = 4096;
  localparam int DEF_SAMPLE_BITS = 16;

  // smallest legal frame edge
  localparam int MIN_COUNT = 3;

  localparam int CFG_ADDR_BITS = 2;
  localparam int QUEUE_DEPTH   = 4;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_ROW_COUNT = 2'd0,
    REG_COL_COUNT = 2'd1
  } l3sf_reg_e;

  // which results one queued item produces
  typedef struct packed {
    logic has_lap;
    logic border;
  } l3sf_kind_t;

  typedef struct packed {
    logic full;
    logic empty;
  } l3sf_qstat_t;

endpackage

>>> src/l3sf_front.sv
// Front end: frame counters, column line buffers, window and partial sums.
module l3sf_front #(
  parameter int MAX_ROWS    = l3sf_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS    = l3sf_pkg::DEF_MAX_COLS,
  parameter int SAMPLE_BITS = l3sf_pkg::DEF_SAMPLE_BITS,
  localparam int RowBits    = $clog2(MAX_ROWS),
  localparam int ColBits    = $clog2(MAX_COLS),
  localparam int RowCntBits = $clog2(MAX_ROWS + 1),
  localparam int ColCntBits = $clog2(MAX_COLS + 1),
  localparam int CfgBits    = (RowCntBits > ColCntBits) ? RowCntBits : ColCntBits,
  localparam int TopBits    = SAMPLE_BITS + 2,
  localparam int MidBits    = SAMPLE_BITS + 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [l3sf_pkg::CFG_ADDR_BITS-1:0]   cfg_addr_i,
  input  logic [CfgBits-1:0]                   cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]        sample_i,
  output logic                                 push_valid_o,
  input  logic                                 push_full_i,
  output l3sf_pkg::l3sf_kind_t                 push_kind_o,
  output logic [RowBits-1:0]                   push_row_o,
  output logic [ColBits-1:0]                   push_col_o,
  output logic signed [SAMPLE_BITS-1:0]        push_sample_o,
  output logic signed [TopBits-1:0]            push_top_o,
  output logic signed [MidBits-1:0]            push_mid_o,
  output logic signed [TopBits-1:0]            push_new_o
);
  import l3sf_pkg::*;

  logic [RowBits-1:0]    row_q, row_d;
  logic [ColBits-1:0]    col_q, col_d;
  logic [RowCntBits-1:0] row_cnt_q, row_cnt_d, row_clamp;
  logic [ColCntBits-1:0] col_cnt_q, col_cnt_d, col_clamp;

  logic                  s1_v_q, s1_v_d;
  logic [RowBits-1:0]    s1_row_q;
  logic [ColBits-1:0]    s1_col_q;
  logic signed [SAMPLE_BITS-1:0] s1_smp_q;
  l3sf_kind_t            s1_kind_q, kind;

  logic signed [SAMPLE_BITS-1:0] rd_a_q, rd_b_q;
  logic signed [SAMPLE_BITS-1:0] win_q [6];

  logic signed [SAMPLE_BITS-1:0] older_mem [MAX_ROWS];
  logic signed [SAMPLE_BITS-1:0] newer_mem [MAX_ROWS];

  logic accept, retire, need_push, last_row, last_col;

  assign last_row = (RowCntBits'(row_q) == row_cnt_q - RowCntBits'(1));
  assign last_col = (ColCntBits'(col_q) == col_cnt_q - ColCntBits'(1));

  always_comb begin
    kind.has_lap = (row_q >= RowBits'(2)) && (col_q >= ColBits'(2));
    kind.border  = (row_q == '0) || last_row || (col_q == '0) || last_col;
  end

  assign need_push    = s1_kind_q.has_lap || s1_kind_q.border;
  assign retire       = s1_v_q && !(need_push && push_full_i);
  assign in_stall_o   = s1_v_q && !retire;
  assign accept       = in_valid_i && !in_stall_o;
  assign push_valid_o = s1_v_q && need_push;

  always_comb begin
    row_clamp = cfg_data_i[RowCntBits-1:0];
    if (row_clamp < RowCntBits'(MIN_COUNT)) begin
      row_clamp = RowCntBits'(MIN_COUNT);
    end else if (row_clamp > RowCntBits'(MAX_ROWS)) begin
      row_clamp = RowCntBits'(MAX_ROWS);
    end
    col_clamp = cfg_data_i[ColCntBits-1:0];
    if (col_clamp < ColCntBits'(MIN_COUNT)) begin
      col_clamp = ColCntBits'(MIN_COUNT);
    end else if (col_clamp > ColCntBits'(MAX_COLS)) begin
      col_clamp = ColCntBits'(MAX_COLS);
    end
  end

  always_comb begin
    row_d     = row_q;
    col_d     = col_q;
    row_cnt_d = row_cnt_q;
    col_cnt_d = col_cnt_q;
    s1_v_d    = s1_v_q;
    if (retire) begin
      s1_v_d = 1'b0;
    end
    if (accept) begin
      s1_v_d = 1'b1;
      // advance the frame position, wrapping after the last column
      if (last_row) begin
        row_d = '0;
        col_d = last_col ? '0 : col_q + ColBits'(1);
      end else begin
        row_d = row_q + RowBits'(1);
      end
    end
    if (cfg_we_i) begin
      case (l3sf_reg_e'(cfg_addr_i))
        REG_ROW_COUNT: begin
          row_cnt_d = row_clamp;
          row_d     = '0;
          col_d     = '0;
        end
        REG_COL_COUNT: begin
          col_cnt_d = col_clamp;
          row_d     = '0;
          col_d     = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      row_cnt_q <= RowCntBits'(MAX_ROWS);
      col_cnt_q <= ColCntBits'(MAX_COLS);
      s1_v_q    <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      row_q     <= row_d;
      col_q     <= col_d;
      row_cnt_q <= row_cnt_d;
      col_cnt_q <= col_cnt_d;
      s1_v_q    <= s1_v_d;
      if (retire) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= rd_a_q;
        win_q[4] <= rd_b_q;
        win_q[5] <= s1_smp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_row_q  <= row_q;
      s1_col_q  <= col_q;
      s1_smp_q  <= sample_i;
      s1_kind_q <= kind;
    end
  end

  // line buffers: read at accept, shift the column pair on retire
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_a_q <= older_mem[row_q];
      rd_b_q <= newer_mem[row_q];
    end
    if (retire) begin
      older_mem[s1_row_q] <= rd_b_q;
      newer_mem[s1_row_q] <= s1_smp_q;
    end
  end

  assign push_kind_o   = s1_kind_q;
  assign push_row_o    = s1_row_q;
  assign push_col_o    = s1_col_q;
  assign push_sample_o = s1_smp_q;
  assign push_top_o    = TopBits'(win_q[0]) + TopBits'(win_q[1]) + TopBits'(win_q[2]);
  assign push_mid_o    = MidBits'(win_q[3]) + MidBits'(win_q[5]) - (MidBits'(win_q[4]) <<< 3);
  assign push_new_o    = TopBits'(rd_a_q) + TopBits'(rd_b_q) + TopBits'(s1_smp_q);

endmodule

>>> src/l3sf_queue.sv
// Small register queue between the front and back ends.
module l3sf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = l3sf_pkg::QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  input  logic [WIDTH-1:0]      push_data_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output logic [WIDTH-1:0]      pop_data_o,
  output l3sf_pkg::l3sf_qstat_t stat_o
);
  import l3sf_pkg::*;

  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntBits = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   mem_q [DEPTH];
  logic [PtrBits-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               push, pop;

  assign stat_o.full  = (cnt_q == CntBits'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign pop_valid_o  = !stat_o.empty;
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && !stat_o.full;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrBits'(DEPTH - 1)) ? '0 : wr_q + PtrBits'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PtrBits'(DEPTH - 1)) ? '0 : rd_q + PtrBits'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntBits'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

>>> src/l3sf_back.sv
// Back end: final Laplacian sum and result sequencing into the output register.
module l3sf_back #(
  parameter int MAX_ROWS    = l3sf_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS    = l3sf_pkg::DEF_MAX_COLS,
  parameter int SAMPLE_BITS = l3sf_pkg::DEF_SAMPLE_BITS,
  localparam int RowBits    = $clog2(MAX_ROWS),
  localparam int ColBits    = $clog2(MAX_COLS),
  localparam int TopBits    = SAMPLE_BITS + 2,
  localparam int MidBits    = SAMPLE_BITS + 4,
  localparam int OutBits    = SAMPLE_BITS + 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  l3sf_pkg::l3sf_kind_t          pop_kind_i,
  input  logic [RowBits-1:0]            pop_row_i,
  input  logic [ColBits-1:0]            pop_col_i,
  input  logic signed [SAMPLE_BITS-1:0] pop_sample_i,
  input  logic signed [TopBits-1:0]     pop_top_i,
  input  logic signed [MidBits-1:0]     pop_mid_i,
  input  logic signed [TopBits-1:0]     pop_new_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [RowBits-1:0]            out_row_o,
  output logic [ColBits-1:0]            out_col_o,
  output logic signed [OutBits-1:0]     out_value_o,
  output logic                          is_filtered_o,
  output logic                          last_o
);
  import l3sf_pkg::*;

  logic                          ex_v_q, ex_v_d;
  logic                          ex_phase_q, ex_phase_d;
  l3sf_kind_t                    ex_kind_q;
  logic [RowBits-1:0]            ex_row_q;
  logic [ColBits-1:0]            ex_col_q;
  logic signed [SAMPLE_BITS-1:0] ex_smp_q;
  logic signed [OutBits-1:0]     ex_lap_q;
  logic                          ov_q, ov_d;

  logic emit_lap, res_last, load_out, ex_free, pop;

  // Laplacian goes first, the border copy second
  assign emit_lap    = ex_kind_q.has_lap && !ex_phase_q;
  assign res_last    = emit_lap ? !ex_kind_q.border : 1'b1;
  assign load_out    = ex_v_q && (!ov_q || !out_stall_i);
  assign ex_free     = !ex_v_q || (load_out && res_last);
  assign pop_ready_o = ex_free;
  assign pop         = pop_valid_i && ex_free;

  always_comb begin
    ex_v_d     = ex_v_q;
    ex_phase_d = ex_phase_q;
    ov_d       = ov_q;
    if (ex_free) begin
      ex_v_d = 1'b0;
    end
    if (load_out && !res_last) begin
      ex_phase_d = 1'b1;
    end
    if (pop) begin
      ex_v_d     = 1'b1;
      ex_phase_d = 1'b0;
    end
    if (load_out) begin
      ov_d = 1'b1;
    end else if (!out_stall_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_v_q     <= 1'b0;
      ex_phase_q <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      ex_v_q     <= ex_v_d;
      ex_phase_q <= ex_phase_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      ex_kind_q <= pop_kind_i;
      ex_row_q  <= pop_row_i;
      ex_col_q  <= pop_col_i;
      ex_smp_q  <= pop_sample_i;
      ex_lap_q  <= OutBits'(pop_top_i) + OutBits'(pop_mid_i) + OutBits'(pop_new_i);
    end
    if (load_out) begin
      out_row_o     <= emit_lap ? ex_row_q - RowBits'(1) : ex_row_q;
      out_col_o     <= emit_lap ? ex_col_q - ColBits'(1) : ex_col_q;
      out_value_o   <= emit_lap ? ex_lap_q : OutBits'(ex_smp_q);
      is_filtered_o <= emit_lap;
      last_o        <= res_last;
    end
  end

  assign out_valid_o = ov_q;

endmodule

>>> src/laplacian_3x3_stencil_filter_core.sv
// Top level of the 3x3 eight-neighbour Laplacian stencil filter.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------------
//   in      | input     | in_valid_i / in_stall_o   | sample_i
//   out     | output    | out_valid_o / out_stall_i | out_row_o out_col_o out_value_o
//           |           |                           | is_filtered_o last_o
//   cfg     | input     | cfg_we_i                  | cfg_addr_i cfg_data_i
//
// One sample per cycle is taken while in_stall_o is low; a sample that makes two results
// (Laplacian plus border copy) loads the output register once per result, Laplacian first.
// Results pass the front stage, the queue, the back-end and output registers.
// Reset clears counters, window and handshake state; line buffers are not cleared.
// Output stall backs up through the back end and the four-entry queue to in_stall_o.
module laplacian_3x3_stencil_filter_core #(
  parameter int MAX_ROWS    = l3sf_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS    = l3sf_pkg::DEF_MAX_COLS,
  parameter int SAMPLE_BITS = l3sf_pkg::DEF_SAMPLE_BITS,
  localparam int RowBits    = $clog2(MAX_ROWS),
  localparam int ColBits    = $clog2(MAX_COLS),
  localparam int RowCntBits = $clog2(MAX_ROWS + 1),
  localparam int ColCntBits = $clog2(MAX_COLS + 1),
  localparam int CfgBits    = (RowCntBits > ColCntBits) ? RowCntBits : ColCntBits,
  localparam int OutBits    = SAMPLE_BITS + 5
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [l3sf_pkg::CFG_ADDR_BITS-1:0] cfg_addr_i,
  input  logic [CfgBits-1:0]                 cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]      sample_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [RowBits-1:0]                 out_row_o,
  output logic [ColBits-1:0]                 out_col_o,
  output logic signed [OutBits-1:0]          out_value_o,
  output logic                               is_filtered_o,
  output logic                               last_o
);
  import l3sf_pkg::*;

  localparam int TopBits   = SAMPLE_BITS + 2;
  localparam int MidBits   = SAMPLE_BITS + 4;
  localparam int KindBits  = $bits(l3sf_kind_t);
  localparam int EntryBits = KindBits + RowBits + ColBits + SAMPLE_BITS
                             + TopBits + MidBits + TopBits;

  logic                          push_valid, pop_valid, pop_ready;
  l3sf_qstat_t                   qstat;
  l3sf_kind_t                    push_kind, pop_kind;
  logic [RowBits-1:0]            push_row, pop_row;
  logic [ColBits-1:0]            push_col, pop_col;
  logic signed [SAMPLE_BITS-1:0] push_smp, pop_smp;
  logic signed [TopBits-1:0]     push_top, pop_top, push_new, pop_new;
  logic signed [MidBits-1:0]     push_mid, pop_mid;
  logic [EntryBits-1:0]          push_data, pop_data;

  l3sf_front #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .push_valid_o (push_valid),
    .push_full_i  (qstat.full),
    .push_kind_o  (push_kind),
    .push_row_o   (push_row),
    .push_col_o   (push_col),
    .push_sample_o(push_smp),
    .push_top_o   (push_top),
    .push_mid_o   (push_mid),
    .push_new_o   (push_new)
  );

  assign push_data = {push_kind, push_row, push_col, push_smp, push_top, push_mid, push_new};

  l3sf_queue #(
    .WIDTH(EntryBits),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data),
    .stat_o      (qstat)
  );

  assign {pop_kind, pop_row, pop_col, pop_smp, pop_top, pop_mid, pop_new} = pop_data;

  l3sf_back #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_kind_i   (pop_kind),
    .pop_row_i    (pop_row),
    .pop_col_i    (pop_col),
    .pop_sample_i (pop_smp),
    .pop_top_i    (pop_top),
    .pop_mid_i    (pop_mid),
    .pop_new_i    (pop_new),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .out_value_o  (out_value_o),
    .is_filtered_o(is_filtered_o),
    .last_o       (last_o)
  );

  // a border copy always closes its sample's results
  a_copy_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_filtered_o |-> last_o)
    else $error("border copy without last");

  // a Laplacian that is not last is followed at once by its border copy
  a_copy_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && is_filtered_o && !last_o |=>
      out_valid_o && !is_filtered_o)
    else $error("border copy did not follow its Laplacian");

  // a filtered centre never lies on the first row or column
  a_centre_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_filtered_o |-> (out_row_o != '0) && (out_col_o != '0))
    else $error("Laplacian centre on first row or column");

  a_queue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qstat.full && qstat.empty))
    else $error("queue both full and empty");

endmodule

>>> sim/tb_laplacian_3x3_stencil_filter_core.sv
// Self-checking testbench for the 3x3 Laplacian stencil filter core.
module tb_laplacian_3x3_stencil_filter_core;
  import l3sf_pkg::*;

  localparam int CFG_DATA_BITS = 13;
  localparam int TAIL_CYCLES   = 8;
  localparam int HOLD_CYCLES   = 150;
  localparam int RANDOM_ITEMS  = 800;
  localparam int RUN_LIMIT     = 12_000_000;

  // addresses outside the register map; writes there must leave the frame alone
  localparam logic [CFG_ADDR_BITS-1:0] SPARE_ADDR_LO = 2'd2;
  localparam logic [CFG_ADDR_BITS-1:0] SPARE_ADDR_HI = 2'd3;

  typedef struct {
    logic [9:0]         row;
    logic [11:0]        col;
    logic signed [20:0] value;
    logic               filtered;
    logic               last;
  } pixel_t;

  class stencil_tracker;
    pixel_t      pending_pixels[$];
    int          older_col[DEF_MAX_ROWS];
    int          newer_col[DEF_MAX_ROWS];
    int          window[6];
    int unsigned row_pos;
    int unsigned col_pos;
    int unsigned rows;
    int unsigned cols;
    int unsigned errors;

    function new();
      rows = DEF_MAX_ROWS;
      cols = DEF_MAX_COLS;
    endfunction

    function int unsigned pending();
      return pending_pixels.size();
    endfunction

    function int unsigned clamp_count(int unsigned v, int unsigned hi);
      if (v < MIN_COUNT) return MIN_COUNT;
      if (v > hi) return hi;
      return v;
    endfunction

    function void set_register(logic [CFG_ADDR_BITS-1:0] addr,
                               logic [CFG_DATA_BITS-1:0] data);
      case (addr)
        REG_ROW_COUNT: rows = clamp_count(data[10:0], DEF_MAX_ROWS);
        REG_COL_COUNT: cols = clamp_count(data, DEF_MAX_COLS);
        default: return;
      endcase
      row_pos = 0;
      col_pos = 0;
    endfunction

    function void absorb_sample(logic signed [15:0] s);
      int     up2;
      int     up1;
      int     cur;
      int     lap;
      bit     on_border;
      pixel_t px;
      up2 = older_col[row_pos];
      up1 = newer_col[row_pos];
      cur = s;
      on_border = (row_pos == 0) || (row_pos == rows - 1) ||
                  (col_pos == 0) || (col_pos == cols - 1);
      if (row_pos >= 2 && col_pos >= 2) begin
        lap = window[0] + window[1] + window[2] + window[3] + window[5]
            + up2 + up1 + cur - 8 * window[4];
        px.row      = 10'(row_pos - 1);
        px.col      = 12'(col_pos - 1);
        px.value    = lap[20:0];
        px.filtered = 1'b1;
        px.last     = !on_border;
        pending_pixels.push_back(px);
      end
      if (on_border) begin
        px.row      = 10'(row_pos);
        px.col      = 12'(col_pos);
        px.value    = s;
        px.filtered = 1'b0;
        px.last     = 1'b1;
        pending_pixels.push_back(px);
      end
      window[0] = window[3];
      window[1] = window[4];
      window[2] = window[5];
      window[3] = up2;
      window[4] = up1;
      window[5] = cur;
      older_col[row_pos] = up1;
      newer_col[row_pos] = cur;
      row_pos++;
      if (row_pos >= rows) begin
        row_pos = 0;
        col_pos++;
        if (col_pos >= cols) col_pos = 0;
      end
    endfunction

    task report(string msg);
      if (errors < 30) $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_pixel(logic [9:0] row, logic [11:0] col, logic signed [20:0] value,
                     logic filtered, logic last);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        report($sformatf("unexpected beat row %0d col %0d", row, col));
        return;
      end
      want = pending_pixels.pop_front();
      if (row !== want.row)
        report($sformatf("row %0d, want %0d", row, want.row));
      if (col !== want.col)
        report($sformatf("col %0d, want %0d (row %0d)", col, want.col, want.row));
      if (value !== want.value)
        report($sformatf("value %0d, want %0d at (%0d,%0d)", value, want.value,
                         want.row, want.col));
      if (filtered !== want.filtered)
        report($sformatf("is_filtered %b, want %b at (%0d,%0d)", filtered,
                         want.filtered, want.row, want.col));
      if (last !== want.last)
        report($sformatf("last %b, want %b at (%0d,%0d)", last, want.last,
                         want.row, want.col));
    endtask
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_ADDR_BITS-1:0]  cfg_addr_i;
  logic [CFG_DATA_BITS-1:0]  cfg_data_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic signed [15:0]        sample_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [9:0]                out_row_o;
  logic [11:0]               out_col_o;
  logic signed [20:0]        out_value_o;
  logic                      is_filtered_o;
  logic                      last_o;

  stencil_tracker sb = new();
  int unsigned    sent_count;
  int unsigned    rx_wait;
  int unsigned    rx_beats;
  bit             hold_on;

  laplacian_3x3_stencil_filter_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .out_value_o  (out_value_o),
    .is_filtered_o(is_filtered_o),
    .last_o       (last_o)
  );

  always #10 clk_i = ~clk_i;

  // receiver: check every beat, then stall for a randomly drawn wait, which is zero in every third run of 97 beats
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_pixel(out_row_o, out_col_o, out_value_o, is_filtered_o, last_o);
      rx_beats++;
      rx_wait = (((rx_beats / 97) % 3) == 1) ? 0 : $urandom_range(0, 7);
    end else if (rx_wait != 0) begin
      rx_wait--;
    end
    out_stall_i <= (rx_wait != 0) || hold_on;
  end

  // hold off the output long enough to back the block up into its input
  initial begin
    for (int k = 0; k < 2; k++) begin
      wait (sent_count >= 400 + k * 1000);
      @(posedge clk_i);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_on <= 1'b0;
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("timeout with %0d results outstanding", sb.pending());
    $display("[laplacian_3x3_stencil_filter_core] ERROR");
    $finish;
  end

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 15) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_sample(logic signed [15:0] s);
    int unsigned gap;
    gap = (((sent_count / 113) % 3) == 2) ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.absorb_sample(s);
    sent_count++;
  endtask

  // drop valid, drain all expected beats, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_ADDR_BITS-1:0] addr,
                                logic [CFG_DATA_BITS-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_register(addr, data);
  endtask

  task automatic apply_frame(logic [CFG_DATA_BITS-1:0] rows_data,
                             logic [CFG_DATA_BITS-1:0] cols_data);
    if ($urandom_range(0, 3) == 0)
      write_register($urandom_range(0, 1) ? SPARE_ADDR_LO : SPARE_ADDR_HI, 13'($urandom));
    if ($urandom_range(0, 1)) begin
      write_register(REG_ROW_COUNT, rows_data);
      write_register(REG_COL_COUNT, cols_data);
    end else begin
      write_register(REG_COL_COUNT, cols_data);
      write_register(REG_ROW_COUNT, rows_data);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [CFG_DATA_BITS-1:0] rows_data;
    logic [CFG_DATA_BITS-1:0] cols_data;
    int unsigned              frame;
    int unsigned              n_items;
    int unsigned              random_sent;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = REG_ROW_COUNT;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    out_stall_i = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry: first column is all border copies
    send_sample(16'sh0001);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    settle();

    // smallest frame, twice in a row to wrap; extreme centre against extreme rim
    apply_frame(13'd3, 13'd3);
    for (int f = 0; f < 2; f++) begin
      for (int i = 0; i < 9; i++) begin
        if (f == 0) send_sample((i == 4) ? 16'sh8000 : 16'sh7fff);
        else        send_sample((i == 4) ? 16'sh7fff : 16'sh8000);
      end
    end
    settle();

    // oversized values clamp to the largest frame; run past the last row
    apply_frame(13'd2047, 13'h1fff);
    for (int i = 0; i < 1030; i++) send_sample(pick_sample());
    settle();

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       rows_data = 13'($urandom_range(0, 2));
        1:       rows_data = 13'($urandom_range(1025, 2047));
        2:       rows_data = (13'd1 << $urandom_range(11, 12)) | 13'($urandom_range(3, 12));
        3:       rows_data = 13'($urandom_range(13, 40));
        default: rows_data = 13'($urandom_range(3, 12));
      endcase
      case ($urandom_range(0, 9))
        0:       cols_data = 13'($urandom_range(0, 2));
        1:       cols_data = 13'($urandom_range(4097, 8191));
        2:       cols_data = 13'd4096;
        default: cols_data = 13'($urandom_range(3, 8));
      endcase
      apply_frame(rows_data, cols_data);
      frame = sb.rows * sb.cols;
      if (frame <= 240)
        n_items = frame * $urandom_range(1, 2) + $urandom_range(0, frame - 1);
      else
        n_items = $urandom_range(40, 160);
      if (n_items > RANDOM_ITEMS - random_sent)
        n_items = RANDOM_ITEMS - random_sent;
      for (int i = 0; i < n_items; i++) send_sample(pick_sample());
      random_sent += n_items;
      settle();
    end

    if (sb.errors == 0) begin
      $display("[laplacian_3x3_stencil_filter_core] OK");
    end else begin
      $display("[laplacian_3x3_stencil_filter_core] ERROR");
    end
    $finish;
  end

endmodule
